FILE: src/assert_macros.svh
// Assertion macros shared by the venturi flow RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define VFD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define VFD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/vfd_pkg.sv
// Shared constants for the venturi flow / air density block
package vfd_pkg;

  localparam int VFD_W = 64;                 // serial unit word width
  localparam int DENSITY_FRAC_BITS_DEF = 16;
  localparam int CD_W = 17;
  localparam logic [CD_W-1:0] CD_RESET = 17'd63898;

  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1073741824;
  localparam logic [63:0] PSAT0_Q16 = 64'd40028078;
  localparam logic [63:0] VAPOUR_K_Q20 = 64'd396343;
  localparam logic [63:0] GAS_RD_MILLI = 64'd287058;
  localparam logic [63:0] FLOW_K_Q16 = 64'd29987268;
  localparam logic [16:0] FLOW_MAX = 17'd100000;

endpackage

FILE: src/vfd_chan_if.sv
// Request and response channel interfaces
interface vfd_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] diff_pressure;
  logic signed [14:0] temp_centi_c;
  logic        [16:0] abs_pressure_pa;
  logic        [13:0] humidity_centi_pct;

  modport source (output valid, opcode, diff_pressure, temp_centi_c, abs_pressure_pa,
                  humidity_centi_pct, input ready);
  modport sink (input valid, opcode, diff_pressure, temp_centi_c, abs_pressure_pa,
                humidity_centi_pct, output ready);
endinterface

interface vfd_rsp_if;
  logic        valid;
  logic        ready;
  logic [16:0] flow_centi_m3h;
  logic [17:0] density_q16;
  logic        flow_saturated;

  modport source (output valid, flow_centi_m3h, density_q16, flow_saturated, input ready);
  modport sink (input valid, flow_centi_m3h, density_q16, flow_saturated, output ready);
endinterface

FILE: src/vfd_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module vfd_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [vfd_pkg::VFD_W-1:0] a,
  input  logic [vfd_pkg::VFD_W-1:0] b,
  output logic                      done,
  output logic [vfd_pkg::VFD_W-1:0] prod
);
  import vfd_pkg::*;

  logic             busy;
  logic [VFD_W-1:0] ma;
  logic [VFD_W-1:0] mb;
  logic [VFD_W-1:0] acc;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ma   <= a;
        mb   <= b;
        acc  <= '0;
      end else if (busy) begin
        if (mb == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mb[0]) acc <= acc + ma;
          ma <= {ma[VFD_W-2:0], 1'b0};
          mb <= {1'b0, mb[VFD_W-1:1]};
        end
      end
    end
  end
endmodule

FILE: src/vfd_div.sv
// Restoring divider, one quotient bit per cycle
module vfd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [vfd_pkg::VFD_W-1:0] n,
  input  logic [vfd_pkg::VFD_W-1:0] d,
  output logic                      done,
  output logic [vfd_pkg::VFD_W-1:0] quo
);
  import vfd_pkg::*;

  localparam int CW = $clog2(VFD_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [VFD_W-1:0] num;
  logic [VFD_W-1:0] den;
  logic [VFD_W:0]   rem;
  logic [VFD_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem[VFD_W-1:0], num[VFD_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign quo    = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        num  <= n;
        den  <= d;
      end else if (busy) begin
        // quotient bits shift in behind the dividend
        num <= {num[VFD_W-2:0], ge};
        rem <= ge ? rem_sh - {1'b0, den} : rem_sh;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VFD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/vfd_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle
module vfd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vfd_pkg::VFD_W-1:0]   v,
  output logic                        done,
  output logic [vfd_pkg::VFD_W/2-1:0] root
);
  import vfd_pkg::*;

  localparam int CW = $clog2(VFD_W / 2);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [VFD_W-1:0] rv;
  logic [VFD_W-1:0] res;
  logic [VFD_W-1:0] bitm;
  logic [VFD_W-1:0] trial;

  assign trial = res + bitm;
  assign root  = res[VFD_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rv   <= v;
        res  <= '0;
        bitm <= {2'b01, {(VFD_W-2){1'b0}}};
      end else if (busy) begin
        if (rv >= trial) begin
          rv  <= rv - trial;
          res <= {1'b0, res[VFD_W-1:1]} + bitm;
        end else begin
          res <= {1'b0, res[VFD_W-1:1]};
        end
        bitm <= {2'b00, bitm[VFD_W-1:2]};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(VFD_W / 2 - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/venturi_flow_with_air_density.sv
// Throughput: one word at a time; set by the bit-serial multiplier (one multiplier bit
//   per cycle), the 64-step divider and the 32-step square root, shared by all steps.
// The next request is taken while the last response waits in the output register.
// Reset: density 1.2 kg/m3, discharge coefficient 0.975, no word in flight.
`include "assert_macros.svh"

module venturi_flow_with_air_density #(
  parameter int DENSITY_FRAC_BITS = vfd_pkg::DENSITY_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  vfd_req_if.sink                  req,
  vfd_rsp_if.source                rsp,
  input  logic                     cfg_we,
  input  logic [vfd_pkg::CD_W-1:0] cfg_data
);
  import vfd_pkg::*;

  localparam int F = DENSITY_FRAC_BITS;
  localparam logic [17:0] RHO_MIN   = 18'((64'd1 << F) / 5);
  localparam logic [63:0] RHO_MAXW  = 64'd2 << F;
  localparam logic [17:0] RHO_MAX   = (RHO_MAXW > 64'd262143) ? 18'd262143 : 18'(RHO_MAXW);
  localparam logic [17:0] RHO_RESET = 18'((64'd6 << F) / 5);
  localparam int NUM_SH = (F >= 16) ? F - 16 : 0;
  localparam int DEN_SH = (F < 16) ? 16 - F : 0;
  localparam logic [22:0] U_BIAS = 23'd4194304;  // 64 in Q16

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001, S_XMUL  = 19'h00002, S_XDIV  = 19'h00004, S_YMUL = 19'h00008,
    S_ZMUL  = 19'h00010, S_HMUL  = 19'h00020, S_HDIV  = 19'h00040, S_MMUL = 19'h00080,
    S_PVMUL = 19'h00100, S_PVDIV = 19'h00200, S_PEMUL = 19'h00400, S_NMUL = 19'h00800,
    S_DMUL  = 19'h01000, S_RDIV  = 19'h02000, S_QDIV  = 19'h04000, S_SQRT = 19'h08000,
    S_KMUL  = 19'h10000, S_FMUL  = 19'h20000, S_FIN   = 19'h40000
  } state_t;

  state_t state;
  logic   issued;

  logic               opc_r;
  logic signed [15:0] dp_r;
  logic signed [14:0] t_r;
  logic        [16:0] pa_r;
  logic        [13:0] hum_r;
  logic [CD_W-1:0]    cd;
  logic [17:0]        rho;
  logic [63:0]        w;
  logic [39:0]        den_r;
  logic [31:0]        p_r;
  logic [29:0]        z_r;
  logic [22:0]        u_r;
  logic [3:0]         k_r;
  logic [25:0]        kc_r;
  logic [16:0]        flow_r;
  logic               sat_r;

  logic        mul_go, div_go, sqrt_go;
  logic        mul_start, div_start, sqrt_start;
  logic        mul_done, div_done, sqrt_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic [63:0] div_n, div_d, div_q;
  logic [31:0] sqrt_r;

  logic [16:0] tx, tt1, tt2;
  logic [15:0] tmag;
  logic [63:0] den1;
  logic [63:0] ymag, vterm, flowv, rq;
  logic signed [39:0] pe;

  function automatic logic [63:0] psat_scale(input logic [63:0] m, input logic [6:0] n);
    logic [7:0]  sh;
    logic [63:0] t1;
    sh = 8'd94 - {1'b0, n};
    t1 = (m >> (sh - 8'd1)) + 64'd1;
    return (sh >= 8'd64) ? 64'd0 : (t1 >> 1);
  endfunction

  assign tx   = {{2{t_r[14]}}, t_r};
  assign tt1  = tx + 17'd23730;
  assign tt2  = tx + 17'd27315;
  assign tmag = t_r[14] ? (~{t_r[14], t_r}) + 16'd1 : {1'b0, t_r};
  assign den1 = 64'(tt1[15:0]) * 64'd100;

  assign ymag  = (mul_p + 64'h2000_0000) >> 30;
  assign vterm = (mul_p + 64'h8_0000) >> 20;
  assign pe    = $signed({7'd0, pa_r, 16'd0}) - $signed({1'b0, vterm[38:0]});
  assign flowv = (mul_p + 64'h2000_0000) >> 30;
  assign rq    = div_q;

  assign req.ready = (state == S_IDLE);

  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    sqrt_go = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = 64'd1;
    case (state)
      S_XMUL:  begin mul_go = 1'b1; mul_a = 64'(tmag); mul_b = 64'd1727; end
      S_XDIV:  begin div_go = 1'b1; div_n = w + (den1 >> 1); div_d = den1; end
      S_YMUL:  begin mul_go = 1'b1; mul_a = w; mul_b = LOG2E_Q30; end
      S_ZMUL:  begin mul_go = 1'b1; mul_a = 64'(u_r[15:0]); mul_b = LN2_Q30; end
      S_HMUL:  begin mul_go = 1'b1; mul_a = 64'(p_r); mul_b = 64'(z_r); end
      S_HDIV:  begin div_go = 1'b1; div_n = w; div_d = 64'(k_r); end
      S_MMUL:  begin mul_go = 1'b1; mul_a = 64'(p_r); mul_b = PSAT0_Q16; end
      S_PVMUL: begin mul_go = 1'b1; mul_a = w; mul_b = 64'(hum_r); end
      S_PVDIV: begin div_go = 1'b1; div_n = w + 64'd5000; div_d = 64'd10000; end
      S_PEMUL: begin mul_go = 1'b1; mul_a = w; mul_b = VAPOUR_K_Q20; end
      S_NMUL:  begin mul_go = 1'b1; mul_a = w; mul_b = 64'd100000; end
      S_DMUL:  begin mul_go = 1'b1; mul_a = 64'(tt2[15:0]); mul_b = GAS_RD_MILLI; end
      S_RDIV:  begin div_go = 1'b1; div_n = w + 64'(den_r >> 1); div_d = 64'(den_r); end
      S_QDIV:  begin div_go = 1'b1; div_n = 64'(dp_r[14:0]) << (F + 28); div_d = 64'(rho); end
      S_SQRT:  sqrt_go = 1'b1;
      S_KMUL:  begin mul_go = 1'b1; mul_a = FLOW_K_Q16; mul_b = 64'(cd); end
      S_FMUL:  begin mul_go = 1'b1; mul_a = 64'(kc_r); mul_b = w; end
      default: ;
    endcase
  end

  assign mul_start  = mul_go && !issued;
  assign div_start  = div_go && !issued;
  assign sqrt_start = sqrt_go && !issued;

  vfd_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_p));
  vfd_div u_div (.clk, .rst, .start(div_start), .n(div_n), .d(div_d),
                 .done(div_done), .quo(div_q));
  vfd_sqrt u_sqrt (.clk, .rst, .start(sqrt_start), .v(w), .done(sqrt_done), .root(sqrt_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      cd        <= CD_RESET;
      rho       <= RHO_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) cd <= cfg_data;
      if (rsp.valid && rsp.ready && state != S_FIN) rsp.valid <= 1'b0;
      if (mul_done || div_done || sqrt_done) issued <= 1'b0;
      else if (mul_start || div_start || sqrt_start) issued <= 1'b1;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            opc_r  <= req.opcode;
            dp_r   <= req.diff_pressure;
            t_r    <= req.temp_centi_c;
            pa_r   <= req.abs_pressure_pa;
            hum_r  <= req.humidity_centi_pct;
            flow_r <= '0;
            sat_r  <= 1'b0;
            if (req.opcode) state <= S_XMUL;
            else if (!req.diff_pressure[15] && req.diff_pressure != '0) state <= S_QDIV;
            else state <= S_FIN;
          end
        end
        S_XMUL: if (mul_done) begin w <= mul_p << 16; state <= S_XDIV; end
        S_XDIV: if (div_done) begin w <= div_q; state <= S_YMUL; end
        S_YMUL: if (mul_done) begin
          // y carries the sign of t; the bias keeps it positive
          u_r   <= t_r[14] ? U_BIAS - ymag[22:0] : U_BIAS + ymag[22:0];
          state <= S_ZMUL;
        end
        S_ZMUL: if (mul_done) begin
          z_r   <= mul_p[45:16];
          p_r   <= ONE_Q30[31:0];
          k_r   <= 4'd8;
          state <= S_HMUL;
        end
        S_HMUL: if (mul_done) begin w <= mul_p >> 30; state <= S_HDIV; end
        S_HDIV: if (div_done) begin
          p_r   <= 32'(ONE_Q30 + div_q);
          k_r   <= k_r - 4'd1;
          state <= (k_r == 4'd1) ? S_MMUL : S_HMUL;
        end
        S_MMUL:  if (mul_done) begin w <= psat_scale(mul_p, u_r[22:16]); state <= S_PVMUL; end
        S_PVMUL: if (mul_done) begin w <= mul_p; state <= S_PVDIV; end
        S_PVDIV: if (div_done) begin w <= div_q; state <= S_PEMUL; end
        S_PEMUL: if (mul_done) begin
          if (pe <= 40'sd0) begin
            rho   <= RHO_MIN;
            state <= S_FIN;
          end else begin
            w     <= 64'(pe[32:0]);
            state <= S_NMUL;
          end
        end
        S_NMUL: if (mul_done) begin w <= mul_p << NUM_SH; state <= S_DMUL; end
        S_DMUL: if (mul_done) begin den_r <= 40'(mul_p << DEN_SH); state <= S_RDIV; end
        S_RDIV: if (div_done) begin
          if (rq < 64'(RHO_MIN)) rho <= RHO_MIN;
          else if (rq > 64'(RHO_MAX)) rho <= RHO_MAX;
          else rho <= rq[17:0];
          state <= S_FIN;
        end
        S_QDIV: if (div_done) begin w <= div_q; state <= S_SQRT; end
        S_SQRT: if (sqrt_done) begin w <= 64'(sqrt_r); state <= S_KMUL; end
        S_KMUL: if (mul_done) begin kc_r <= mul_p[41:16]; state <= S_FMUL; end
        S_FMUL: if (mul_done) begin
          if (flowv > 64'(FLOW_MAX)) begin
            flow_r <= FLOW_MAX;
            sat_r  <= 1'b1;
          end else begin
            flow_r <= flowv[16:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.flow_centi_m3h <= flow_r;
            rsp.density_q16    <= rho;
            rsp.flow_saturated <= sat_r;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VFD_CHECK(a_sat_value, rsp.valid && rsp.flow_saturated, rsp.flow_centi_m3h == FLOW_MAX, "saturated flow not at maximum")
  `VFD_CHECK(a_rho_range, rsp.valid, rsp.density_q16 >= RHO_MIN && rsp.density_q16 <= RHO_MAX, "density out of clamp range")
  `VFD_CHECK_NEXT(a_busy_after_accept, req.valid && req.ready, state != S_IDLE, "accepted word left sequencer idle")
  `VFD_CHECK(a_update_no_flow, state == S_FIN && opc_r, flow_r == '0 && !sat_r, "density update carries flow")

endmodule
